>>> src/hrhp_pkg.sv
package hrhp_pkg;

	// Default build values for the top-level parameters.
	localparam int unsigned VERSION_WIDTH_DEF = 16;
	localparam int unsigned QUEUE_DEPTH_DEF   = 4;

	// Width of the version fields as they leave the block.
	localparam int unsigned VERSION_OUT_WIDTH = 16;

	// Character constants used by the classifier.
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SP    = 8'h20;
	localparam logic [7:0] CHR_DEL   = 8'd127;
	localparam logic [7:0] CHR_CASE  = 8'd32;

	// Field class codes on the result channel.
	localparam logic [2:0] CLS_DELIM  = 3'd0;
	localparam logic [2:0] CLS_METHOD = 3'd1;
	localparam logic [2:0] CLS_URL    = 3'd2;
	localparam logic [2:0] CLS_NAME   = 3'd3;
	localparam logic [2:0] CLS_VALUE  = 3'd4;
	localparam logic [2:0] CLS_BODY   = 3'd5;

	// One classified byte, as it travels from the front end to the engine.
	typedef struct packed {
		logic       clear;
		logic [7:0] raw;
		logic [7:0] lower;
		logic       tok;
		logic       blank;
		logic       is_sp;
		logic       is_cr;
		logic       is_lf;
		logic       is_colon;
		logic       is_dot;
		logic       is_slash;
		logic       is_h;
		logic       is_t;
		logic       is_p;
		logic       is_digit;
		logic [3:0] digit;
	} item_t;

	// One result, as held in the engine's output register.
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [2:0]  field_class;
		logic        token_start;
		logic        prepend_space;
		logic        header_commit;
		logic [15:0] major_version;
		logic [15:0] minor_version;
		logic        request_done;
		logic        parse_error;
	} rsp_t;

	// Handshake between the queue and the engine.
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage

>>> src/hrhp_if.sv
interface hrhp_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface hrhp_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [2:0]  field_class;
	logic        token_start;
	logic        prepend_space;
	logic        header_commit;
	logic [15:0] major_version;
	logic [15:0] minor_version;
	logic        request_done;
	logic        parse_error;

	modport source (
		output valid, output out_byte, output field_class, output token_start,
		output prepend_space, output header_commit, output major_version,
		output minor_version, output request_done, output parse_error,
		input ready
	);
	modport sink (
		input valid, input out_byte, input field_class, input token_start,
		input prepend_space, input header_commit, input major_version,
		input minor_version, input request_done, input parse_error,
		output ready
	);
endinterface

>>> src/hrhp_front.sv
module hrhp_front (
	input  logic            op,
	input  logic [7:0]      data_byte,
	output hrhp_pkg::item_t item
);
	import hrhp_pkg::*;

	// Token characters: bytes above space up to and including DEL, minus the separators.
	function automatic logic is_tok(input logic [7:0] c);
		logic ok;
		ok = (c > CHR_SP) && (c <= CHR_DEL);
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
			"[", "]", "?", "=", "{", "}": ok = 1'b0;
			default: ;
		endcase
		return ok;
	endfunction

	logic is_upper;

	assign is_upper = (data_byte >= "A") && (data_byte <= "Z");

	always_comb begin
		item.clear    = op;
		item.raw      = data_byte;
		item.lower    = is_upper ? data_byte + CHR_CASE : data_byte;
		item.tok      = is_tok(data_byte);
		item.is_sp    = data_byte == CHR_SP;
		item.blank    = (data_byte == CHR_SP) || (data_byte == CHR_TAB);
		item.is_cr    = data_byte == CHR_CR;
		item.is_lf    = data_byte == CHR_LF;
		item.is_colon = data_byte == ":";
		item.is_dot   = data_byte == ".";
		item.is_slash = data_byte == "/";
		item.is_h     = data_byte == "H";
		item.is_t     = data_byte == "T";
		item.is_p     = data_byte == "P";
		item.is_digit = (data_byte >= "0") && (data_byte <= "9");
		item.digit    = 4'(data_byte - "0");
	end

endmodule

>>> src/hrhp_queue.sv
module hrhp_queue #(
	parameter int unsigned DEPTH = hrhp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  hrhp_pkg::item_t        push_item,
	output logic                   not_full,
	output hrhp_pkg::queue_out_t   head,
	input  logic                   pop
);
	import hrhp_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign not_full   = count_q != CW'(DEPTH);
	assign do_push    = push && not_full;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = count_q != '0;
	assign head.item  = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/hrhp_engine.sv
module hrhp_engine #(
	parameter int unsigned VERSION_WIDTH = hrhp_pkg::VERSION_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hrhp_pkg::queue_out_t head,
	output logic                 pop,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output hrhp_pkg::rsp_t       rsp
);
	import hrhp_pkg::*;

	localparam int unsigned VW = VERSION_WIDTH;

	typedef enum logic [4:0] {
		ST_VERB, ST_URL, ST_V_H, ST_V_T1, ST_V_T2, ST_V_P, ST_V_SLASH,
		ST_NUM1, ST_NUM2, ST_START_LF, ST_HDR_NL, ST_HDR_CONT, ST_HDR_NAME,
		ST_HDR_COLON, ST_VAL_LWS, ST_VALUE, ST_VAL_LF, ST_BLANK_LF, ST_BODY,
		ST_FAIL
	} state_t;

	state_t        state_q, state_n;
	logic [VW-1:0] major_q, major_n;
	logic [VW-1:0] minor_q, minor_n;
	logic          digit_seen_q, digit_seen_n;
	logic          token_ne_q, token_ne_n;
	logic          name_ne_q, name_ne_n;
	logic          value_ne_q, value_ne_n;
	logic          rsp_valid_q;
	rsp_t          rsp_q, rsp_n;
	item_t         it;

	// Multiply by ten and add a digit, saturating at the counter's maximum.
	function automatic logic [VW-1:0] add_digit(input logic [VW-1:0] cnt,
			input logic [3:0] d);
		logic [VW+3:0] wide;
		logic [VW+3:0] sum;
		wide = {4'b0, cnt};
		sum  = (wide << 3) + (wide << 1) + {{VW{1'b0}}, d};
		return (sum > {4'b0, {VW{1'b1}}}) ? {VW{1'b1}} : sum[VW-1:0];
	endfunction

	function automatic logic [15:0] show(input logic [VW-1:0] cnt);
		logic [VW+15:0] ext;
		ext = {16'b0, cnt};
		return ext[15:0];
	endfunction

	assign it        = head.item;
	assign pop       = head.valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		logic vb;
		state_n      = state_q;
		major_n      = major_q;
		minor_n      = minor_q;
		digit_seen_n = digit_seen_q;
		token_ne_n   = token_ne_q;
		name_ne_n    = name_ne_q;
		value_ne_n   = value_ne_q;
		vb           = 1'b0;
		rsp_n               = '0;
		rsp_n.out_byte      = it.raw;
		rsp_n.field_class   = CLS_DELIM;

		case (state_q)
			ST_VERB: begin
				if (it.tok) begin
					rsp_n.field_class = CLS_METHOD;
					rsp_n.token_start = !token_ne_q;
					token_ne_n        = 1'b1;
				end else if (token_ne_q && it.is_sp) begin
					state_n    = ST_URL;
					token_ne_n = 1'b0;
				end else begin
					state_n = ST_FAIL;
				end
			end
			ST_URL: begin
				if (!it.is_sp) begin
					rsp_n.field_class = CLS_URL;
					rsp_n.token_start = !token_ne_q;
					token_ne_n        = 1'b1;
				end else if (token_ne_q) begin
					state_n    = ST_V_H;
					token_ne_n = 1'b0;
				end else begin
					state_n = ST_FAIL;
				end
			end
			ST_V_H:  state_n = it.is_h ? ST_V_T1 : ST_FAIL;
			ST_V_T1: state_n = it.is_t ? ST_V_T2 : ST_FAIL;
			ST_V_T2: state_n = it.is_t ? ST_V_P : ST_FAIL;
			ST_V_P:  state_n = it.is_p ? ST_V_SLASH : ST_FAIL;
			ST_V_SLASH: begin
				state_n      = it.is_slash ? ST_NUM1 : ST_FAIL;
				digit_seen_n = 1'b0;
			end
			ST_NUM1: begin
				if (it.is_digit) begin
					major_n      = add_digit(major_q, it.digit);
					digit_seen_n = 1'b1;
				end else if (digit_seen_q && it.is_dot) begin
					state_n      = ST_NUM2;
					digit_seen_n = 1'b0;
				end else begin
					state_n = ST_FAIL;
				end
			end
			ST_NUM2: begin
				if (it.is_digit) begin
					minor_n      = add_digit(minor_q, it.digit);
					digit_seen_n = 1'b1;
				end else if (digit_seen_q && it.is_cr) begin
					state_n = ST_START_LF;
				end else begin
					state_n = ST_FAIL;
				end
			end
			ST_START_LF: state_n = it.is_lf ? ST_HDR_NL : ST_FAIL;
			ST_HDR_NL: begin
				if (it.blank) begin
					state_n = name_ne_q ? ST_HDR_CONT : ST_FAIL;
				end else begin
					if (name_ne_q) begin
						rsp_n.header_commit = 1'b1;
						name_ne_n           = 1'b0;
						value_ne_n          = 1'b0;
					end
					if (it.is_cr) begin
						state_n = ST_BLANK_LF;
					end else if (it.tok) begin
						state_n           = ST_HDR_NAME;
						name_ne_n         = 1'b1;
						rsp_n.field_class = CLS_NAME;
						rsp_n.token_start = 1'b1;
						rsp_n.out_byte    = it.lower;
					end else begin
						state_n = ST_FAIL;
					end
				end
			end
			ST_HDR_NAME: begin
				if (it.tok) begin
					rsp_n.field_class = CLS_NAME;
					rsp_n.out_byte    = it.lower;
				end else if (it.blank) begin
					state_n = ST_HDR_COLON;
				end else if (it.is_colon) begin
					state_n = ST_VAL_LWS;
				end else begin
					state_n = ST_FAIL;
				end
			end
			ST_HDR_COLON: begin
				if (it.is_colon) begin
					state_n = ST_VAL_LWS;
				end else if (!it.blank) begin
					state_n = ST_FAIL;
				end
			end
			ST_VAL_LWS, ST_HDR_CONT: begin
				if (!it.blank) begin
					if (it.is_cr) begin
						state_n = ST_FAIL;
					end else begin
						state_n             = ST_VALUE;
						vb                  = 1'b1;
						rsp_n.token_start   = !value_ne_q;
						rsp_n.prepend_space = value_ne_q;
					end
				end
			end
			ST_VALUE: begin
				if (it.is_cr) begin
					state_n = ST_VAL_LF;
				end else begin
					vb = 1'b1;
				end
			end
			ST_VAL_LF:   state_n = it.is_lf ? ST_HDR_NL : ST_FAIL;
			ST_BLANK_LF: state_n = it.is_lf ? ST_BODY : ST_FAIL;
			ST_BODY:     rsp_n.field_class = CLS_BODY;
			ST_FAIL:     state_n = ST_FAIL;
			default:     state_n = ST_FAIL;
		endcase

		if (vb) begin
			rsp_n.field_class = CLS_VALUE;
			value_ne_n        = 1'b1;
		end
		if (state_n == ST_FAIL) begin
			rsp_n.field_class   = CLS_DELIM;
			rsp_n.token_start   = 1'b0;
			rsp_n.prepend_space = 1'b0;
		end
		rsp_n.major_version = show(major_n);
		rsp_n.minor_version = show(minor_n);
		rsp_n.request_done  = state_n == ST_BODY;
		rsp_n.parse_error   = state_n == ST_FAIL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_VERB;
			major_q      <= '0;
			minor_q      <= '0;
			digit_seen_q <= 1'b0;
			token_ne_q   <= 1'b0;
			name_ne_q    <= 1'b0;
			value_ne_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (pop) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (pop) begin
				if (it.clear) begin
					state_q      <= ST_VERB;
					major_q      <= '0;
					minor_q      <= '0;
					digit_seen_q <= 1'b0;
					token_ne_q   <= 1'b0;
					name_ne_q    <= 1'b0;
					value_ne_q   <= 1'b0;
					rsp_q        <= '0;
				end else begin
					state_q      <= state_n;
					major_q      <= major_n;
					minor_q      <= minor_n;
					digit_seen_q <= digit_seen_n;
					token_ne_q   <= token_ne_n;
					name_ne_q    <= name_ne_n;
					value_ne_q   <= value_ne_n;
					rsp_q        <= rsp_n;
				end
			end
		end
	end

endmodule

>>> src/http_request_header_parser.sv
// Path: a byte transferred on the request side is written into the queue, then taken
// by the engine into its output register; a result waits there while the result side stalls.
// Throughput: one byte per cycle, sustained, while the result side accepts every result.
// Reset: arst_n clears the queue, the output register and the parser state, which
// starts in the method state with zero version counts.
module http_request_header_parser #(
	parameter int unsigned VERSION_WIDTH = hrhp_pkg::VERSION_WIDTH_DEF,
	parameter int unsigned QUEUE_DEPTH   = hrhp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	hrhp_req_if.sink          req,
	hrhp_rsp_if.source        rsp
);
	import hrhp_pkg::*;

	// The front end classifies each incoming byte without any state: token
	// character, blank, digit with its value, the few literal characters the
	// grammar needs, and the lower-case form used for header names. A clear
	// request travels through the same path as a flag on the item, so it keeps
	// its place in the byte stream.
	item_t      cls_item;
	logic       q_not_full;
	queue_out_t q_head;
	logic       q_pop;
	rsp_t       rsp_data;

	hrhp_front u_front (
		.op        (req.op),
		.data_byte (req.data_byte),
		.item      (cls_item)
	);

	// A transfer on the request side happens whenever the queue has room; the
	// queue does not depend on the result side in the same cycle, so the two
	// channels stall independently.
	assign req.ready = q_not_full;

	hrhp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req.valid),
		.push_item (cls_item),
		.not_full  (q_not_full),
		.head      (q_head),
		.pop       (q_pop)
	);

	// The engine runs the request-line and header state machine. It takes the
	// head of the queue whenever its output register is empty or is being
	// drained in the same cycle, so a steady stream moves one byte per clock.
	hrhp_engine #(
		.VERSION_WIDTH (VERSION_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp       (rsp_data)
	);

	// The result register fields map one to one onto the result channel.
	assign rsp.out_byte      = rsp_data.out_byte;
	assign rsp.field_class   = rsp_data.field_class;
	assign rsp.token_start   = rsp_data.token_start;
	assign rsp.prepend_space = rsp_data.prepend_space;
	assign rsp.header_commit = rsp_data.header_commit;
	assign rsp.major_version = rsp_data.major_version;
	assign rsp.minor_version = rsp_data.minor_version;
	assign rsp.request_done  = rsp_data.request_done;
	assign rsp.parse_error   = rsp_data.parse_error;

endmodule

>>> test/tb_http_request_header_parser.sv
module tb_http_request_header_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import hrhp_pkg::*;

	// The block is built with its default version width, and the model below
	// saturates its counts at the same width.
	localparam int unsigned      VW           = VERSION_WIDTH_DEF;
	localparam longint unsigned  COUNT_CAP    = (64'd1 << VW) - 1;
	localparam int               LIMIT_CYCLES = 200000;
	localparam int               LONG_HOLD    = 300;
	localparam int               ITEM_TARGET  = 1450;
	localparam int               MAX_PRINTED  = 40;

	// Grammar positions of the parser, as the model tracks them.
	typedef enum logic [4:0] {
		S_METHOD, S_URL, S_VER_H, S_VER_T1, S_VER_T2, S_VER_P, S_VER_SLASH,
		S_MAJOR, S_MINOR, S_LINE_LF, S_LINE_START, S_FOLD, S_NAME, S_COLON,
		S_VALUE_LWS, S_VALUE, S_VALUE_LF, S_BLANK_LF, S_BODY, S_ERROR
	} grammar_state_t;

	logic clk;
	logic arst_n;

	hrhp_req_if req_if();
	hrhp_rsp_if rsp_if();

	http_request_header_parser #(
		.VERSION_WIDTH(VW),
		.QUEUE_DEPTH  (QUEUE_DEPTH_DEF)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Model state: grammar position, version counts and the flags that say
	// whether the current token, header name and header value have bytes.
	grammar_state_t  gstate;
	longint unsigned major_acc;
	longint unsigned minor_acc;
	bit              digit_seen;
	bit              token_open;
	bit              name_open;
	bit              value_open;

	// Tagged bytes predicted for transfers accepted so far, oldest first.
	rsp_t pending_tags[$];

	int  bytes_sent   = 0;
	int  tags_checked = 0;
	int  mismatches   = 0;
	int  body_tags    = 0;
	int  error_tags   = 0;
	int  commit_tags  = 0;
	int  cycle_count  = 0;
	int  stall_left   = 0;
	bit  sender_gaps     = 1'b1;
	bit  receiver_stalls = 1'b1;
	bit  hold_active     = 1'b0;
	event long_hold_go;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Model of the parser
	// ---------------------------------------------------------------------

	function automatic bit is_token(input logic [7:0] c);
		if (c <= CHR_SP || c > CHR_DEL)
			return 1'b0;
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
			"=", "{", "}": return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CHR_SP || c == CHR_TAB;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Decimal accumulation that sticks at the largest count the width holds.
	function automatic longint unsigned add_digit(input longint unsigned count,
			input logic [7:0] c);
		longint unsigned v;
		v = count * 10 + (c - "0");
		return (v > COUNT_CAP) ? COUNT_CAP : v;
	endfunction

	function automatic void reset_grammar();
		gstate     = S_METHOD;
		major_acc  = 0;
		minor_acc  = 0;
		digit_seen = 1'b0;
		token_open = 1'b0;
		name_open  = 1'b0;
		value_open = 1'b0;
	endfunction

	// Works out the tagged byte for one transfer and advances the model.
	function automatic rsp_t predict_tag(input logic op, input logic [7:0] c);
		rsp_t           r;
		grammar_state_t nxt;
		bit             value_byte;
		r = '0;
		if (op) begin
			reset_grammar();
			return r;
		end
		nxt        = gstate;
		value_byte = 1'b0;
		r.out_byte    = c;
		r.field_class = CLS_DELIM;
		case (gstate)
			S_METHOD: begin
				if (is_token(c)) begin
					r.field_class = CLS_METHOD;
					r.token_start = !token_open;
					token_open = 1'b1;
				end else if (token_open && c == CHR_SP) begin
					nxt = S_URL;
					token_open = 1'b0;
				end else begin
					nxt = S_ERROR;
				end
			end
			S_URL: begin
				if (c != CHR_SP) begin
					r.field_class = CLS_URL;
					r.token_start = !token_open;
					token_open = 1'b1;
				end else if (token_open) begin
					nxt = S_VER_H;
					token_open = 1'b0;
				end else begin
					nxt = S_ERROR;
				end
			end
			S_VER_H:  nxt = (c == "H") ? S_VER_T1 : S_ERROR;
			S_VER_T1: nxt = (c == "T") ? S_VER_T2 : S_ERROR;
			S_VER_T2: nxt = (c == "T") ? S_VER_P : S_ERROR;
			S_VER_P:  nxt = (c == "P") ? S_VER_SLASH : S_ERROR;
			S_VER_SLASH: begin
				nxt = (c == "/") ? S_MAJOR : S_ERROR;
				digit_seen = 1'b0;
			end
			S_MAJOR: begin
				if (is_digit(c)) begin
					major_acc = add_digit(major_acc, c);
					digit_seen = 1'b1;
				end else if (digit_seen && c == ".") begin
					nxt = S_MINOR;
					digit_seen = 1'b0;
				end else begin
					nxt = S_ERROR;
				end
			end
			S_MINOR: begin
				if (is_digit(c)) begin
					minor_acc = add_digit(minor_acc, c);
					digit_seen = 1'b1;
				end else if (digit_seen && c == CHR_CR) begin
					nxt = S_LINE_LF;
				end else begin
					nxt = S_ERROR;
				end
			end
			S_LINE_LF: nxt = (c == CHR_LF) ? S_LINE_START : S_ERROR;
			S_LINE_START: begin
				if (is_blank(c)) begin
					nxt = name_open ? S_FOLD : S_ERROR;
				end else begin
					// Any other first byte closes the header before it.
					if (name_open) begin
						r.header_commit = 1'b1;
						name_open  = 1'b0;
						value_open = 1'b0;
					end
					if (c == CHR_CR) begin
						nxt = S_BLANK_LF;
					end else if (is_token(c)) begin
						nxt = S_NAME;
						name_open = 1'b1;
						r.field_class = CLS_NAME;
						r.token_start = 1'b1;
						r.out_byte = (c >= "A" && c <= "Z") ? c + CHR_CASE : c;
					end else begin
						nxt = S_ERROR;
					end
				end
			end
			S_NAME: begin
				if (is_token(c)) begin
					r.field_class = CLS_NAME;
					r.out_byte = (c >= "A" && c <= "Z") ? c + CHR_CASE : c;
				end else if (is_blank(c)) begin
					nxt = S_COLON;
				end else if (c == ":") begin
					nxt = S_VALUE_LWS;
				end else begin
					nxt = S_ERROR;
				end
			end
			S_COLON: begin
				if (c == ":")
					nxt = S_VALUE_LWS;
				else if (!is_blank(c))
					nxt = S_ERROR;
			end
			S_VALUE_LWS, S_FOLD: begin
				if (c == CHR_CR) begin
					nxt = S_ERROR;
				end else if (!is_blank(c)) begin
					nxt = S_VALUE;
					value_byte = 1'b1;
					r.token_start   = !value_open;
					r.prepend_space = value_open;
				end
			end
			S_VALUE: begin
				if (c == CHR_CR)
					nxt = S_VALUE_LF;
				else
					value_byte = 1'b1;
			end
			S_VALUE_LF: nxt = (c == CHR_LF) ? S_LINE_START : S_ERROR;
			S_BLANK_LF: nxt = (c == CHR_LF) ? S_BODY : S_ERROR;
			S_BODY:     r.field_class = CLS_BODY;
			S_ERROR:    ;
			default:    nxt = S_ERROR;
		endcase
		if (value_byte) begin
			r.field_class = CLS_VALUE;
			value_open = 1'b1;
		end
		if (nxt == S_ERROR) begin
			r.field_class   = CLS_DELIM;
			r.token_start   = 1'b0;
			r.prepend_space = 1'b0;
		end
		gstate = nxt;
		r.major_version = major_acc[VERSION_OUT_WIDTH-1:0];
		r.minor_version = minor_acc[VERSION_OUT_WIDTH-1:0];
		r.request_done  = (nxt == S_BODY);
		r.parse_error   = (nxt == S_ERROR);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------

	// Offers one byte and waits for its transfer. With gaps enabled, a random
	// burst of idle cycles may come first. The model is updated only once the
	// transfer has actually happened.
	task automatic send_byte(input logic op, input logic [7:0] b);
		rsp_t tag;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 9)) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_if.valid     <= 1'b1;
		req_if.op        <= op;
		req_if.data_byte <= b;
		do
			@(posedge clk);
		while (!req_if.ready);
		tag = predict_tag(op, b);
		pending_tags.push_back(tag);
		bytes_sent++;
		body_tags   += int'(tag.request_done);
		error_tags  += int'(tag.parse_error);
		commit_tags += int'(tag.header_commit);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(1'b0, s[i]);
	endtask

	function automatic bit chance(input int n);
		return $urandom_range(0, n - 1) == 0;
	endfunction

	function automatic logic [7:0] rand_token();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h21, 8'h7F));
		while (!is_token(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_blank();
		return chance(2) ? CHR_SP : CHR_TAB;
	endfunction

	function automatic void append_text(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	// Version digits: usually one or two, sometimes enough to saturate, and
	// now and then none at all.
	function automatic void append_digits(ref logic [7:0] q[$]);
		int n;
		n = chance(15) ? $urandom_range(5, 7) : chance(30) ? 0 : $urandom_range(1, 2);
		repeat (n) q.push_back(8'("0" + $urandom_range(0, 9)));
	endfunction

	// One value segment: arbitrary bytes other than CR, ended by CR LF. The
	// segment is occasionally empty, which the grammar rejects.
	function automatic void append_value(ref logic [7:0] q[$]);
		logic [7:0] c;
		int         n;
		n = chance(30) ? 0 : $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == CHR_CR || (i == 0 && is_blank(c)));
			q.push_back(c);
		end
		q.push_back(CHR_CR);
		q.push_back(CHR_LF);
	endfunction

	// Builds a request that is mostly well formed, with random content, the
	// occasional grammar slip, corruption or truncation, and sends it. Usually
	// a clear follows so the next request starts from the method again; when
	// it does not, the next request goes on from wherever the last one left the grammar.
	task automatic send_random_request();
		logic [7:0] msg[$];
		int         n;
		n = chance(30) ? 0 : $urandom_range(1, 4);
		repeat (n) msg.push_back(rand_token());
		msg.push_back(CHR_SP);
		n = chance(30) ? 0 : $urandom_range(1, 5);
		repeat (n) msg.push_back(chance(2) ? 8'("/") : 8'($urandom_range(8'h21, 8'hFF)));
		msg.push_back(CHR_SP);
		append_text(msg, "HTTP/");
		append_digits(msg);
		msg.push_back(".");
		append_digits(msg);
		msg.push_back(CHR_CR);
		msg.push_back(CHR_LF);
		if (chance(20))
			msg.push_back(rand_blank());
		repeat ($urandom_range(0, 3)) begin
			n = chance(30) ? 0 : $urandom_range(1, 5);
			repeat (n) msg.push_back(rand_token());
			if (chance(3))
				msg.push_back(rand_blank());
			msg.push_back(chance(30) ? CHR_CR : ":");
			repeat ($urandom_range(0, 2)) msg.push_back(rand_blank());
			append_value(msg);
			if (chance(4)) begin
				repeat ($urandom_range(1, 2)) msg.push_back(rand_blank());
				append_value(msg);
			end
		end
		msg.push_back(CHR_CR);
		msg.push_back(CHR_LF);
		repeat ($urandom_range(0, 4)) msg.push_back(8'($urandom_range(0, 255)));
		if (chance(8))
			msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
		if (chance(10)) begin
			n = $urandom_range(1, msg.size());
			while (msg.size() > n)
				void'(msg.pop_back());
		end
		foreach (msg[i])
			send_byte(1'b0, msg[i]);
		if (!chance(10))
			send_byte(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------------

	// Ready drops for random stall bursts while stalls are on,
	// and stays low for the whole of a long hold.
	always @(negedge clk) begin
		if (hold_active) begin
			rsp_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// The long hold counts its own cycles so the request side can keep
	// offering bytes until the block's queue is full and it drops ready.
	initial forever begin
		@(long_hold_go);
		hold_active = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_active = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t mismatch on result %0d, %s: got %0h, expected %0h",
				$realtime, tags_checked, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Every result transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_tags.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(rsp_if.out_byte), 0);
			end else begin
				want = pending_tags[0];
				pending_tags.delete(0);
				check_field("out_byte", 32'(rsp_if.out_byte), 32'(want.out_byte));
				check_field("field_class", 32'(rsp_if.field_class),
					32'(want.field_class));
				check_field("token_start", 32'(rsp_if.token_start),
					32'(want.token_start));
				check_field("prepend_space", 32'(rsp_if.prepend_space),
					32'(want.prepend_space));
				check_field("header_commit", 32'(rsp_if.header_commit),
					32'(want.header_commit));
				check_field("major_version", 32'(rsp_if.major_version),
					32'(want.major_version));
				check_field("minor_version", 32'(rsp_if.minor_version),
					32'(want.minor_version));
				check_field("request_done", 32'(rsp_if.request_done),
					32'(want.request_done));
				check_field("parse_error", 32'(rsp_if.parse_error),
					32'(want.parse_error));
			end
			tags_checked++;
		end
	end

	// Run limit, far above the slowest correct run.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results pending",
			cycle_count, pending_tags.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Clears with both extreme data bytes, an empty method, and a byte in the
	// error state that must leave the error standing.
	task automatic test_clears_and_extremes();
		send_byte(1'b1, 8'h00);
		send_byte(1'b1, 8'hFF);
		send_byte(1'b0, CHR_SP);
		send_byte(1'b0, 8'hFF);
		send_byte(1'b1, 8'h00);
	endtask

	// A complete request: digit nine in the version, a mixed-case header
	// name, a value folded onto a tab-led line, the blank line and a body.
	// The octal escapes are CR, LF and TAB.
	task automatic test_well_formed_request();
		send_text("G /");
		send_byte(1'b0, 8'hFF);
		send_text(" HTTP/9.10\015\012Ho: A\015\012\011b\015\012\015\012");
		send_byte(1'b0, 8'h00);
		send_byte(1'b1, 8'h5A);
	endtask

	// Each short request breaks the grammar in one place.
	task automatic test_grammar_errors();
		// Empty URL.
		send_text("M  ");
		send_byte(1'b1, 8'h00);
		// Saturating major version, then a header name with no colon.
		send_text("M / HTTP/9999999.1\015\012k\015");
		send_byte(1'b1, 8'h00);
		// Folded line with no header before it.
		send_text("M / HTTP/1.1\015\012 x");
		send_byte(1'b1, 8'h00);
		// Folded line whose segment is empty.
		send_text("M / HTTP/1.1\015\012k:v\015\012 \015");
		send_byte(1'b1, 8'h00);
		// A header is committed even when the next line starts badly.
		send_text("M / HTTP/1.1\015\012k:v\015\012@!");
		send_byte(1'b1, 8'h00);
	endtask

	task automatic test_random_requests();
		while (bytes_sent < ITEM_TARGET - 250)
			send_random_request();
	endtask

	// The result side holds off for a long stretch while bytes keep coming,
	// so the block fills up and stalls its input.
	task automatic test_output_backpressure();
		-> long_hold_go;
		sender_gaps = 1'b0;
		repeat (2) send_random_request();
		sender_gaps = 1'b1;
	endtask

	// Back-to-back transfers on both sides to close the run.
	task automatic test_streaming();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		while (bytes_sent < ITEM_TARGET)
			send_random_request();
	endtask

	initial begin
		req_if.valid     = 1'b0;
		req_if.op        = 1'b0;
		req_if.data_byte = 8'h00;
		rsp_if.ready     = 1'b0;
		arst_n           = 1'b0;
		reset_grammar();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_clears_and_extremes();
		test_well_formed_request();
		test_grammar_errors();
		test_random_requests();
		test_output_backpressure();
		test_streaming();

		@(negedge clk);
		req_if.valid <= 1'b0;
		// Results trail the inputs through the queue and the result register; the
		// extra wait catches any stray result after the last expected one.
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run: %0d transfers in, %0d results checked, %0d mismatches",
			bytes_sent, tags_checked, mismatches);
		$display("Covered %0d body bytes, %0d error bytes, %0d header commits, one long hold",
			body_tags, error_tags, commit_tags);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/hrhp_pkg.sv
src/hrhp_if.sv
src/hrhp_front.sv
src/hrhp_queue.sv
src/hrhp_engine.sv
src/http_request_header_parser.sv
test/tb_http_request_header_parser.sv
